// File: rtl/vpec_pkg.sv
// Package for the vertex projection and edge cull block.
// Shared types (commands, status, edge record), widths and helpers.
// No dependencies.
package vpec_pkg;

    localparam int unsigned CFG_IDX_W = 4;
    localparam int unsigned CFG_DAT_W = 64;
    localparam int unsigned VP_W      = 15;
    localparam int unsigned COL_W     = 50;   // signed column sum, Q.24
    localparam int unsigned MAG_W     = 49;   // column magnitude
    localparam int unsigned QUO_W     = 31;   // quotient bits when not saturated
    localparam int unsigned PROD_W    = 48;

    localparam logic [CFG_IDX_W-1:0] REG_ROW0   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW2   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW3   = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VP_X   = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_VP_Y   = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_VP_W   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_VP_H   = 4'd7;

    localparam logic [63:0] ROW0_RST = 64'h0000_0000_0000_0100;
    localparam logic [63:0] ROW1_RST = 64'h0000_0000_0100_0000;
    localparam logic [63:0] ROW2_RST = 64'h0000_0100_0000_0000;
    localparam logic [63:0] ROW3_RST = 64'h0100_0000_0000_0000;
    localparam logic [VP_W-1:0] VP_W_RST = 15'd640;
    localparam logic [VP_W-1:0] VP_H_RST = 15'd480;

    localparam logic [1:0] SEL_X = 2'd0;
    localparam logic [1:0] SEL_Y = 2'd1;
    localparam logic [1:0] SEL_Z = 2'd2;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_MAC,
        OP_DIV_START,
        OP_DIV_STEP,
        OP_DIV_STORE,
        OP_SMUL_X,
        OP_SMUL_Y,
        OP_SCR_X,
        OP_SCR_Y,
        OP_COMMIT
    } t_op;

    typedef struct packed {
        logic       load;   // capture the input request
        t_op        op;
        logic [1:0] col;    // matrix column for OP_MAC
        logic [1:0] term;   // row term for OP_MAC
        logic [1:0] sel;    // coordinate for the divider
    } t_cmd;

    typedef struct packed {
        logic out_empty;
    } t_status;

    typedef struct packed {
        logic [15:0] sx;
        logic [15:0] sy;
        logic [15:0] ex;
        logic [15:0] ey;
        logic        last;
    } t_edge;

    // Q16.16 to integer pixel, truncated toward zero
    function automatic logic [15:0] pixel(input logic signed [31:0] s);
        logic signed [32:0] t;
        t = {s[31], s} + (s[31] ? 33'sd65535 : 33'sd0);
        return t[31:16];
    endfunction

endpackage

// File: rtl/vertex_project_edge_cull.sv
// Vertex projection with viewport mapping and edge culling, top level.
// Joins the controller (vpec_ctrl) and the datapath (vpec_dp).
// Depends on vpec_pkg.
//
// Usage:
//  - Input channel (i_valid/o_ready) carries one vertex per request:
//    Q16.16 x, y, z plus first/last polygon flags.
//  - Output channel (o_valid/i_ready) carries edge requests: integer
//    start/end pixels and last_segment, set on the final edge of a vertex.
//    A vertex yields zero, one or two segments.
//  - Config channel (i_cfg_valid/o_cfg_ready) writes the matrix rows and
//    viewport registers; always ready; write only while idle.
//  - Sequence per vertex, from accept to the next accept: multiply-accumulate
//    on the shared 32x16 multiplier, then three divisions by w on the
//    one-bit-per-cycle restoring divider, then viewport mapping and a commit.
//    A new vertex is accepted only once the last one has been committed.
//  - Edges sit in a two-entry output buffer; a new vertex is accepted while
//    they wait. A stalled receiver only holds up the commit of the next
//    vertex, which waits until the buffer has drained.
//  - Synchronous active-low reset restores the identity matrix, a 640x480
//    viewport at the origin, and closes any open polygon.
module vertex_project_edge_cull (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [vpec_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [vpec_pkg::CFG_DAT_W-1:0]     i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic signed [31:0]                 i_vertex_x,
    input  logic signed [31:0]                 i_vertex_y,
    input  logic signed [31:0]                 i_vertex_z,
    input  logic                               i_first_vertex,
    input  logic                               i_last_vertex,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [15:0]                 o_start_x,
    output logic signed [15:0]                 o_start_y,
    output logic signed [15:0]                 o_end_x,
    output logic signed [15:0]                 o_end_y,
    output logic                               o_last_segment
);
    import vpec_pkg::*;

    t_cmd    cmd;
    t_status status;
    t_edge   out_edge;

    vpec_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    vpec_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_vertex_x     (i_vertex_x),
        .i_vertex_y     (i_vertex_y),
        .i_vertex_z     (i_vertex_z),
        .i_first_vertex (i_first_vertex),
        .i_last_vertex  (i_last_vertex),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_edge         (out_edge)
    );

    assign o_start_x      = out_edge.sx;
    assign o_start_y      = out_edge.sy;
    assign o_end_x        = out_edge.ex;
    assign o_end_y        = out_edge.ey;
    assign o_last_segment = out_edge.last;

`ifndef NO_ASSERTIONS
    // one vertex in work at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input accepted while a vertex was in work");

    // a non-final edge is always followed by the closing edge
    a_second_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last_segment |=> o_valid && o_last_segment)
        else $error("closing edge missing after first edge");
`endif

endmodule

// File: rtl/vpec_ctrl.sv
// Controller for the vertex projection and edge cull block.
// Sequences the multiply-accumulate, the three divisions, the viewport
// mapping and the edge commit. Depends on vpec_pkg.
module vpec_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  vpec_pkg::t_status i_status,
    output vpec_pkg::t_cmd    o_cmd
);
    import vpec_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_MAC, S_DRAIN, S_DSTART, S_DSTEP, S_DSTORE,
        S_SMULX, S_SCRX, S_SMULY, S_SCRY, S_COMMIT
    } t_state;

    t_state     r_state;
    logic [1:0] r_col;
    logic [1:0] r_term;
    logic [1:0] r_sel;
    logic [4:0] r_step;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd      = '0;
        o_cmd.op   = OP_NONE;
        o_cmd.load = i_valid && o_ready;
        o_cmd.col  = r_col;
        o_cmd.term = r_term;
        o_cmd.sel  = r_sel;
        case (r_state)
            S_MAC:    o_cmd.op = OP_MAC;
            S_DSTART: o_cmd.op = OP_DIV_START;
            S_DSTEP:  o_cmd.op = OP_DIV_STEP;
            S_DSTORE: o_cmd.op = OP_DIV_STORE;
            S_SMULX:  o_cmd.op = OP_SMUL_X;
            S_SCRX:   o_cmd.op = OP_SCR_X;
            S_SMULY:  o_cmd.op = OP_SMUL_Y;
            S_SCRY:   o_cmd.op = OP_SCR_Y;
            S_COMMIT: o_cmd.op = i_status.out_empty ? OP_COMMIT : OP_NONE;
            default:  o_cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_col   <= '0;
            r_term  <= '0;
            r_sel   <= '0;
            r_step  <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_col  <= '0;
                    r_term <= '0;
                    if (i_valid) begin
                        r_state <= S_MAC;
                    end
                end
                S_MAC: begin
                    if (r_term == 2'd2) begin
                        r_term <= '0;
                        r_col  <= r_col + 2'd1;
                        if (r_col == 2'd3) begin
                            r_state <= S_DRAIN;
                        end
                    end else begin
                        r_term <= r_term + 2'd1;
                    end
                end
                S_DRAIN: begin
                    r_sel   <= SEL_X;
                    r_state <= S_DSTART;
                end
                S_DSTART: begin
                    r_step  <= '0;
                    r_state <= S_DSTEP;
                end
                S_DSTEP: begin
                    r_step <= r_step + 5'd1;
                    if (r_step == 5'(QUO_W - 1)) begin
                        r_state <= S_DSTORE;
                    end
                end
                S_DSTORE: begin
                    if (r_sel == SEL_Z) begin
                        r_state <= S_SMULX;
                    end else begin
                        r_sel   <= r_sel + 2'd1;
                        r_state <= S_DSTART;
                    end
                end
                S_SMULX: r_state <= S_SCRX;
                S_SCRX:  r_state <= S_SMULY;
                S_SMULY: r_state <= S_SCRY;
                S_SCRY:  r_state <= S_COMMIT;
                S_COMMIT: begin
                    if (i_status.out_empty) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// File: rtl/vpec_dp.sv
// Datapath for the vertex projection and edge cull block: config registers,
// shared multiplier, accumulator, restoring divider, viewport mapping,
// polygon state and the two-slot result buffer. Depends on vpec_pkg.
module vpec_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  vpec_pkg::t_cmd                      i_cmd,
    output vpec_pkg::t_status                   o_status,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [vpec_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [vpec_pkg::CFG_DAT_W-1:0]      i_cfg_data,
    input  logic signed [31:0]                  i_vertex_x,
    input  logic signed [31:0]                  i_vertex_y,
    input  logic signed [31:0]                  i_vertex_z,
    input  logic                                i_first_vertex,
    input  logic                                i_last_vertex,
    output logic                                o_valid,
    input  logic                                i_ready,
    output vpec_pkg::t_edge                     o_edge
);
    import vpec_pkg::*;

    // configuration
    logic [63:0]     r_row0, r_row1, r_row2, r_row3;
    logic [VP_W-1:0] r_vp_x, r_vp_y, r_vp_w, r_vp_h;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row0 <= ROW0_RST;
            r_row1 <= ROW1_RST;
            r_row2 <= ROW2_RST;
            r_row3 <= ROW3_RST;
            r_vp_x <= '0;
            r_vp_y <= '0;
            r_vp_w <= VP_W_RST;
            r_vp_h <= VP_H_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_ROW0: r_row0 <= i_cfg_data;
                REG_ROW1: r_row1 <= i_cfg_data;
                REG_ROW2: r_row2 <= i_cfg_data;
                REG_ROW3: r_row3 <= i_cfg_data;
                REG_VP_X: r_vp_x <= i_cfg_data[VP_W-1:0];
                REG_VP_Y: r_vp_y <= i_cfg_data[VP_W-1:0];
                REG_VP_W: r_vp_w <= i_cfg_data[VP_W-1:0];
                REG_VP_H: r_vp_h <= i_cfg_data[VP_W-1:0];
                default: ;
            endcase
        end
    end

    // input capture
    logic signed [31:0] r_vx, r_vy, r_vz;
    logic               r_first, r_last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_vx    <= i_vertex_x;
            r_vy    <= i_vertex_y;
            r_vz    <= i_vertex_z;
            r_first <= i_first_vertex;
            r_last  <= i_last_vertex;
        end
    end

    // shared multiplier
    logic signed [31:0]       mul_a;
    logic signed [15:0]       mul_b;
    logic [63:0]              mac_row;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_prod_v;
    logic [1:0]               r_prod_col, r_prod_term;
    logic signed [31:0]       r_nx, r_ny, r_nz;

    always_comb begin
        case (i_cmd.term)
            2'd0:    begin mul_a = r_vx; mac_row = r_row0; end
            2'd1:    begin mul_a = r_vy; mac_row = r_row1; end
            default: begin mul_a = r_vz; mac_row = r_row2; end
        endcase
        mul_b = mac_row[16*i_cmd.col +: 16];
        if (i_cmd.op == OP_SMUL_X) begin
            mul_a = r_nx;
            mul_b = {1'b0, r_vp_w};
        end else if (i_cmd.op == OP_SMUL_Y) begin
            mul_a = r_ny;
            mul_b = {1'b0, r_vp_h};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_v <= 1'b0;
        end else begin
            r_prod_v <= (i_cmd.op == OP_MAC);
        end
        r_prod      <= mul_a * mul_b;
        r_prod_col  <= i_cmd.col;
        r_prod_term <= i_cmd.term;
    end

    // column accumulation
    logic signed [COL_W-1:0] r_acc, acc_next;
    logic signed [COL_W-1:0] r_cx, r_cy, r_cz, r_cw;
    logic signed [15:0]      e3;

    always_comb begin
        e3 = r_row3[16*r_prod_col +: 16];
        if (r_prod_term == 2'd0) begin
            acc_next = {{2{r_prod[PROD_W-1]}}, r_prod}
                     + {{18{e3[15]}}, e3, 16'b0};
        end else begin
            acc_next = r_acc + {{2{r_prod[PROD_W-1]}}, r_prod};
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_prod_v) begin
            r_acc <= acc_next;
            if (r_prod_term == 2'd2) begin
                case (r_prod_col)
                    2'd0:    r_cx <= acc_next;
                    2'd1:    r_cy <= acc_next;
                    2'd2:    r_cz <= acc_next;
                    default: r_cw <= acc_next;
                endcase
            end
        end
    end

    // restoring divider on magnitudes, 31 quotient bits
    logic signed [COL_W-1:0] div_num;
    logic [COL_W-1:0]        abs_n, abs_d;
    logic [MAG_W-1:0]        r_ud;
    logic [MAG_W-1:0]        r_rem;
    logic [QUO_W-1:0]        r_numlo, r_q;
    logic                    r_neg, r_sat, r_wz;
    logic [MAG_W:0]          trial;
    logic [31:0]             div_val;

    always_comb begin
        case (i_cmd.sel)
            SEL_X:   div_num = r_cx;
            SEL_Y:   div_num = r_cy;
            default: div_num = r_cz;
        endcase
        abs_n = div_num[COL_W-1] ? -div_num : div_num;
        abs_d = r_cw[COL_W-1] ? -r_cw : r_cw;
        trial = {r_rem, r_numlo[QUO_W-1]};
        if (r_wz) begin
            div_val = '0;
        end else if (r_sat) begin
            div_val = r_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            div_val = r_neg ? -{1'b0, r_q} : {1'b0, r_q};
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_DIV_START: begin
                r_neg   <= div_num[COL_W-1] ^ r_cw[COL_W-1];
                r_wz    <= (r_cw == '0);
                r_ud    <= abs_d[MAG_W-1:0];
                // integer part of n/d reaches 2^15
                r_sat   <= {15'b0, abs_n[MAG_W-1:0]} >= {abs_d[MAG_W-1:0], 15'b0};
                r_rem   <= MAG_W'(abs_n[MAG_W-1:15]);
                r_numlo <= {abs_n[14:0], 16'b0};
                r_q     <= '0;
            end
            OP_DIV_STEP: begin
                r_numlo <= {r_numlo[QUO_W-2:0], 1'b0};
                if (trial >= {1'b0, r_ud}) begin
                    r_rem <= MAG_W'(trial - {1'b0, r_ud});
                    r_q   <= {r_q[QUO_W-2:0], 1'b1};
                end else begin
                    r_rem <= trial[MAG_W-1:0];
                    r_q   <= {r_q[QUO_W-2:0], 1'b0};
                end
            end
            OP_DIV_STORE: begin
                case (i_cmd.sel)
                    SEL_X:   r_nx <= div_val;
                    SEL_Y:   r_ny <= div_val;
                    default: r_nz <= div_val;
                endcase
            end
            default: ;
        endcase
    end

    // viewport mapping
    logic signed [48:0] scr_t, scr_h;
    logic signed [31:0] scr_sat;
    logic signed [31:0] r_sx, r_sy;

    always_comb begin
        if (i_cmd.op == OP_SCR_Y) begin
            scr_t = -{r_prod[PROD_W-1], r_prod}
                  + {17'b0, r_vp_y, 17'b0} + {18'b0, r_vp_h, 16'b0};
        end else begin
            scr_t = {r_prod[PROD_W-1], r_prod}
                  + {17'b0, r_vp_x, 17'b0} + {18'b0, r_vp_w, 16'b0};
        end
        // halve, rounding toward zero
        scr_h = (scr_t + $signed({48'b0, scr_t[48]})) >>> 1;
        if (scr_h > 49'sh0_7FFF_FFFF) begin
            scr_sat = 32'h7FFF_FFFF;
        end else if (scr_h < -49'sh0_8000_0000) begin
            scr_sat = 32'h8000_0000;
        end else begin
            scr_sat = scr_h[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_SCR_X) r_sx <= scr_sat;
        if (i_cmd.op == OP_SCR_Y) r_sy <= scr_sat;
    end

    // polygon state and edge commit
    logic signed [31:0] r_first_x, r_first_y, r_prev_x, r_prev_y;
    logic               r_first_vis, r_prev_vis, r_have_prev;
    logic               vis, starts, e1, e2, fvis;
    logic signed [31:0] fx, fy;
    t_edge              edge1, edge2;
    t_edge              r_slot0, r_slot1;
    logic               r_s0_v, r_s1_v;

    always_comb begin
        vis = !r_wz && !r_nz[31] && (r_nz <= 32'sd65536)
            && !r_sx[31] && (r_sx[30:0] < {r_vp_w, 16'b0})
            && !r_sy[31] && (r_sy[30:0] < {r_vp_h, 16'b0});
        starts = r_first || !r_have_prev;
        fx     = starts ? r_sx : r_first_x;
        fy     = starts ? r_sy : r_first_y;
        fvis   = starts ? vis : r_first_vis;
        e1     = !starts && (r_prev_vis || vis);
        e2     = r_last && (vis || fvis);
        edge1  = '{sx: pixel(r_prev_x), sy: pixel(r_prev_y),
                   ex: pixel(r_sx), ey: pixel(r_sy), last: !e2};
        edge2  = '{sx: pixel(r_sx), sy: pixel(r_sy),
                   ex: pixel(fx), ey: pixel(fy), last: 1'b1};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_prev <= 1'b0;
            r_first_vis <= 1'b0;
            r_prev_vis  <= 1'b0;
            r_first_x   <= '0;
            r_first_y   <= '0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_s0_v      <= 1'b0;
            r_s1_v      <= 1'b0;
        end else begin
            if (r_s0_v && i_ready) begin
                r_s0_v  <= r_s1_v;
                r_s1_v  <= 1'b0;
                r_slot0 <= r_slot1;
            end
            if (i_cmd.op == OP_COMMIT) begin
                r_first_x   <= fx;
                r_first_y   <= fy;
                r_first_vis <= fvis;
                r_prev_x    <= r_sx;
                r_prev_y    <= r_sy;
                r_prev_vis  <= vis;
                r_have_prev <= !r_last;
                r_s0_v      <= e1 || e2;
                r_s1_v      <= e1 && e2;
                r_slot0     <= e1 ? edge1 : edge2;
                r_slot1     <= edge2;
            end
        end
    end

    assign o_valid            = r_s0_v;
    assign o_edge             = r_slot0;
    assign o_status.out_empty = !r_s0_v;

endmodule

// File: test/vertex_project_edge_cull_tb.sv
// Self-checking testbench for vertex_project_edge_cull: projection, viewport mapping and
// edge culling are predicted per vertex and checked edge by edge on the output channel.
// Depends on vpec_pkg and the RTL top level.
`timescale 1ns / 100ps

module vertex_project_edge_cull_tb;
    import vpec_pkg::*;

    localparam int CYC_LIMIT = 20000;   // cycles with no request accepted
    localparam int SETTLE    = 300;     // settle time after the queues have drained

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               first;
        logic               last;
    } t_vtx;

    typedef struct {
        logic [15:0] sx, sy, ex, ey;
        logic        last;
    } t_seg;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data = '0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic signed [31:0] i_vertex_x = '0, i_vertex_y = '0, i_vertex_z = '0;
    logic i_first_vertex = 1'b0, i_last_vertex = 1'b0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic signed [15:0] o_start_x, o_start_y, o_end_x, o_end_y;
    logic o_last_segment;

    always #1 i_clk = ~i_clk;

    vertex_project_edge_cull u_top (.*);

    // predictor copy of registers and polygon state
    logic [63:0] mrow [4];
    longint vp_x0, vp_y0, vp_w, vp_h;
    longint poly_fx, poly_fy, poly_px, poly_py;
    bit     poly_fvis, poly_pvis, poly_open;

    t_vtx  vtx_q [$];
    t_seg  seg_q [$];
    int    n_err = 0, n_vtx = 0, n_seg = 0, idle_cnt = 0;
    bit    rx_burst_ok = 1'b1, drv_gaps = 1'b1;
    bit    hold_rx = 1'b0;
    int    drv_gap = 0, rx_gap = 0;

    function automatic longint q_entry(logic [63:0] row, int j);
        logic signed [15:0] e;
        e = row[16*j +: 16];
        return longint'(e);
    endfunction

    function automatic longint sat32(longint v);
        if (v < -64'sd2147483648) return -64'sd2147483648;
        if (v > 64'sd2147483647) return 64'sd2147483647;
        return v;
    endfunction

    function automatic longint div_ndc(longint num, longint den);
        bit neg;
        longint un, ud, ip, rem, frac;
        neg  = (num < 0) != (den < 0);
        un   = num < 0 ? -num : num;
        ud   = den < 0 ? -den : den;
        ip   = un / ud;
        rem  = un % ud;
        frac = 0;
        if (ip >= 32768) return neg ? -64'sd2147483648 : 64'sd2147483647;
        for (int i = 0; i < 16; i++) begin
            rem = rem << 1;
            frac = frac << 1;
            if (rem >= ud) begin
                rem -= ud;
                frac |= 1;
            end
        end
        return neg ? -((ip << 16) | frac) : ((ip << 16) | frac);
    endfunction

    function automatic logic [15:0] to_pixel(longint s);
        longint p;
        p = s / 65536;
        if (p < -32768) p = -32768;
        if (p > 32767) p = 32767;
        return p[15:0];
    endfunction

    function automatic t_seg make_seg(longint ax, ay, bx, by);
        t_seg s;
        s.sx = to_pixel(ax);
        s.sy = to_pixel(ay);
        s.ex = to_pixel(bx);
        s.ey = to_pixel(by);
        s.last = 1'b0;
        return s;
    endfunction

    task automatic predict_edges(t_vtx v);
        longint c [4];
        longint vin [3];
        longint nx, ny, nz, sx, sy;
        bit     vis, starts;
        int     n0;
        vin[0] = v.x;
        vin[1] = v.y;
        vin[2] = v.z;
        for (int j = 0; j < 4; j++)
            c[j] = vin[0] * q_entry(mrow[0], j) + vin[1] * q_entry(mrow[1], j)
                 + vin[2] * q_entry(mrow[2], j) + q_entry(mrow[3], j) * 65536;
        nx = 0; ny = 0; nz = 0; vis = 1'b0;
        // zero w: outside, maps to viewport center
        if (c[3] != 0) begin
            nx = div_ndc(c[0], c[3]);
            ny = div_ndc(c[1], c[3]);
            nz = div_ndc(c[2], c[3]);
            vis = nz >= 0 && nz <= 65536;
        end
        sx = sat32((nx * vp_w + vp_x0 * 131072 + vp_w * 65536) / 2);
        sy = sat32((-ny * vp_h + vp_y0 * 131072 + vp_h * 65536) / 2);
        vis = vis && sx >= 0 && sx < vp_w * 65536 && sy >= 0 && sy < vp_h * 65536;
        starts = v.first || !poly_open;
        n0 = seg_q.size();
        if (starts) begin
            poly_fx = sx;
            poly_fy = sy;
            poly_fvis = vis;
        end else if (poly_pvis || vis) begin
            seg_q.push_back(make_seg(poly_px, poly_py, sx, sy));
        end
        // closing edge back to the first vertex
        if (v.last && (vis || poly_fvis))
            seg_q.push_back(make_seg(sx, sy, poly_fx, poly_fy));
        if (seg_q.size() > n0) seg_q[$].last = 1'b1;
        poly_px = sx;
        poly_py = sy;
        poly_pvis = vis;
        poly_open = !v.last;
    endtask

    task automatic report(string what);
        n_err++;
        $display("ERROR @%0t: %s", $realtime, what);
    endtask

    // driver: takes pending vertices; random gaps between requests
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                predict_edges(vtx_q.pop_front());
                n_vtx++;
            end
            if (!i_valid || o_ready) begin
                if (drv_gap > 0) begin
                    drv_gap <= drv_gap - 1;
                    i_valid <= 1'b0;
                end else if (vtx_q.size() > (i_valid && o_ready ? 0 : 0)) begin
                    i_valid <= 1'b1;
                    i_vertex_x <= vtx_q[0].x;
                    i_vertex_y <= vtx_q[0].y;
                    i_vertex_z <= vtx_q[0].z;
                    i_first_vertex <= vtx_q[0].first;
                    i_last_vertex <= vtx_q[0].last;
                    if (drv_gaps && $urandom_range(0, 5) == 0) drv_gap <= $urandom_range(1, 17);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver stalls
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                n_seg++;
                if (seg_q.size() == 0) begin
                    report("edge with none expected");
                end else begin
                    t_seg e;
                    e = seg_q.pop_front();
                    if (o_start_x !== e.sx || o_start_y !== e.sy || o_end_x !== e.ex
                        || o_end_y !== e.ey || o_last_segment !== e.last)
                        report($sformatf("edge (%0d,%0d)-(%0d,%0d) l%0b exp (%0d,%0d)-(%0d,%0d) l%0b",
                            o_start_x, o_start_y, o_end_x, o_end_y, o_last_segment,
                            $signed(e.sx), $signed(e.sy), $signed(e.ex), $signed(e.ey),
                            e.last));
                end
            end
            if (hold_rx) begin
                i_ready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap <= rx_gap - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                if (rx_burst_ok && $urandom_range(0, 5) == 0) rx_gap <= $urandom_range(1, 17);
            end
        end
    end

    // watchdog on accepted requests
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready)
            || hold_rx)
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= CYC_LIMIT) begin
            $display("watchdog: no progress, %0d vertices %0d edges", n_vtx, n_seg);
            $display("vertex_project_edge_cull: mismatch");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_ROW0: mrow[0] = val;
            REG_ROW1: mrow[1] = val;
            REG_ROW2: mrow[2] = val;
            REG_ROW3: mrow[3] = val;
            REG_VP_X: vp_x0 = val[14:0];
            REG_VP_Y: vp_y0 = val[14:0];
            REG_VP_W: vp_w = val[14:0];
            REG_VP_H: vp_h = val[14:0];
            default: ;
        endcase
    endtask

    task automatic drain;
        wait (vtx_q.size() == 0 && !i_valid);
        wait (seg_q.size() == 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rnd_q88();
        case ($urandom_range(0, 4))
            0: return 16'h0100;
            1: return 16'hFF00;
            2: return 16'h0000;
            default: return 16'($urandom_range(0, 16'h0400)) - 16'h0200;
        endcase
    endfunction

    function automatic logic signed [31:0] rnd_coord();
        case ($urandom_range(0, 7))
            0: return 32'($urandom());
            1: return 32'sh7FFF_FFFF;
            2: return 32'sh8000_0000;
            default: return 32'($signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000);
        endcase
    endfunction

    task automatic add_vtx(logic signed [31:0] x, y, z, logic f, l);
        t_vtx v;
        v.x = x; v.y = y; v.z = z; v.first = f; v.last = l;
        vtx_q.push_back(v);
    endtask

    // polygons mostly well formed; some broken or restarted
    task automatic add_polys(int count);
        int k, len;
        k = 0;
        while (k < count) begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++) begin
                add_vtx(rnd_coord(), rnd_coord(), rnd_coord(),
                        i == 0 ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 19) == 0),
                        i == len - 1 ? ($urandom_range(0, 9) != 0) : 1'b0);
                k++;
            end
        end
    endtask

    task automatic rnd_matrix(bit proj);
        logic [63:0] r;
        for (int i = 0; i < 4; i++) begin
            r = {rnd_q88(), rnd_q88(), rnd_q88(), rnd_q88()};
            if (i == 3 && proj) r[63:48] = 16'h0100;
            write_reg(REG_ROW0 + CFG_IDX_W'(i), r);
        end
    endtask

    initial begin
        mrow[0] = ROW0_RST; mrow[1] = ROW1_RST; mrow[2] = ROW2_RST; mrow[3] = ROW3_RST;
        vp_x0 = 0; vp_y0 = 0; vp_w = VP_W_RST; vp_h = VP_H_RST;
        poly_fx = 0; poly_fy = 0; poly_px = 0; poly_py = 0;
        poly_fvis = 0; poly_pvis = 0; poly_open = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset identity and 640x480: in view, out of view, restart, single
        add_vtx(32'sh0000_8000, 32'sh0000_8000, 32'sh0000_8000, 0, 0);  // no polygon open
        add_vtx(-32'sh0000_8000, 32'sh0000_4000, 32'sh0000_0000, 0, 0);
        add_vtx(32'sh0001_0000, -32'sh0001_0000, 32'sh0001_0000, 0, 1);
        add_vtx(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 1, 0);
        add_vtx(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0);
        add_vtx(32'sh0000_1000, 32'sh0000_1000, 32'sh0000_1000, 1, 0);   // restart
        add_vtx(0, 0, 32'sh0002_0000, 0, 1);
        add_vtx(0, 0, 0, 1, 1);                                          // single vertex
        add_vtx(-1, -1, -1, 1, 1);
        drain();
        // zero w: row 3 all zero, so the w column is all zero
        write_reg(REG_ROW3, 64'h0);
        add_vtx(0, 0, 0, 1, 0);
        add_vtx(32'sh0001_0000, 0, 0, 0, 1);
        drain();
        // extreme viewport, unknown register index, height zero masking
        write_reg(REG_ROW3, ROW3_RST);
        write_reg(REG_VP_X, 64'h7FFF);
        write_reg(REG_VP_Y, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_VP_W, 64'h7FFF);
        write_reg(REG_VP_H, 64'h8000);   // masks to zero height
        write_reg(4'd12, 64'h1234);
        add_vtx(0, 0, 32'sh0000_8000, 1, 0);
        add_vtx(32'sh0000_8000, 0, 0, 0, 1);
        drain();
        write_reg(REG_VP_X, 64'd1);
        write_reg(REG_VP_Y, 64'd1);
        write_reg(REG_VP_W, 64'd1);
        write_reg(REG_VP_H, 64'd1);
        add_vtx(0, 0, 0, 1, 0);
        add_vtx(-32'sh0001_0000, 32'sh0001_0000, 32'sh0000_8000, 0, 1);
        drain();

        // random phases with different settings
        for (int ph = 0; ph < 6; ph++) begin
            rnd_matrix(ph % 2 == 0);
            write_reg(REG_VP_X, 64'($urandom_range(0, 200)));
            write_reg(REG_VP_Y, 64'($urandom_range(0, 200)));
            write_reg(REG_VP_W, ph == 5 ? 64'h7FFF : 64'($urandom_range(1, 1000)));
            write_reg(REG_VP_H, ph == 5 ? 64'h7FFF : 64'($urandom_range(1, 1000)));
            if (ph == 2) begin
                // long receiver hold while vertices keep coming
                add_polys(30);
                @(posedge i_clk);
                hold_rx = 1'b1;
                repeat (3000) @(posedge i_clk);
                hold_rx = 1'b0;
            end else begin
                add_polys(ph == 0 ? 100 : 200);
            end
            if (ph == 5) begin
                rx_burst_ok = 1'b0;
                drv_gaps = 1'b0;
            end
            drain();
        end

        $display("covered %0d vertices and %0d edges over directed and six random phases",
                 n_vtx, n_seg);
        $display("matrix, viewport extremes, zero w, restarts and receiver back-pressure");
        if (n_err == 0)
            $display("vertex_project_edge_cull: match");
        else
            $display("vertex_project_edge_cull: mismatch");
        $finish;
    end

endmodule

// File: files.f
rtl/vpec_pkg.sv
rtl/vpec_ctrl.sv
rtl/vpec_dp.sv
rtl/vertex_project_edge_cull.sv
test/vertex_project_edge_cull_tb.sv
